/* rtl/three_wire_sensor_serial_master_assert.svh */
// assertion macros used by the serial master checker
`ifndef THREE_WIRE_SENSOR_SERIAL_MASTER_ASSERT_SVH
`define THREE_WIRE_SENSOR_SERIAL_MASTER_ASSERT_SVH

// consequent must hold in the cycle after the antecedent
`define TWS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("tws assertion failed");

// consequent must hold in the same cycle as the antecedent
`define TWS_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("tws assertion failed");

`endif

/* rtl/tws_pkg.sv */
// types and constants of the three-wire sensor serial master
`timescale 1ns / 1ps

package tws_pkg;

  typedef enum logic [1:0] {
    OP_NONE   = 2'd0,
    OP_READ   = 2'd1,
    OP_WRITE  = 2'd2,
    OP_RESYNC = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_ADDR      = 3'd1,
    PH_READ      = 3'd2,
    PH_WRITE     = 3'd3,
    PH_SYNC_LOW  = 3'd4,
    PH_SYNC_WAIT = 3'd5
  } phase_e;

  // configuration register indexes
  localparam logic [1:0] CFG_HALF_PERIOD = 2'd0;
  localparam logic [1:0] CFG_RESYNC_LOW  = 2'd1;
  localparam logic [1:0] CFG_RESYNC_WAIT = 2'd2;

  localparam int unsigned CNT_W = 20;
  localparam logic [7:0]       HALF_PERIOD_RST = 8'd4;
  localparam logic [15:0]      RESYNC_LOW_RST  = 16'd1000;
  localparam logic [19:0]      RESYNC_WAIT_RST = 20'd2000;
  localparam logic [3:0]       BITS_PER_BYTE   = 4'd8;

  typedef struct packed {
    op_e        opcode;
    logic [6:0] reg_address;
    logic [7:0] write_data;
    logic       sdio_in;
    logic       tick;
  } tws_in_t;

  typedef struct packed {
    logic       sclk;
    logic       sdio_out;
    logic       sdio_drive;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_data;
  } tws_out_t;

endpackage

/* rtl/three_wire_sensor_serial_master.sv */
// three_wire_sensor_serial_master: top level of the half-duplex sensor bus master
//
// each input word is one system clock: a command (looked at only while idle),
// the sampled data pin and a tick flag that advances all bus timing. every
// accepted input word yields exactly one output word with the pin levels,
// busy/done flags and the last byte read, reflecting the state after that word.
// read/write send an address byte msb first (bit 7 set for write), then read
// or write one data byte; resync holds sclk low then high for set tick counts.
// the output word is registered and appears in the cycle after its input word is accepted.
// throughput: one word per cycle while the output is taken; the bus state and
// next-state logic update in the cycle of acceptance, and the output register
// holds the result. when the receiver stalls, the output word is held and input
// ready drops only while the output register is full and not being taken.
// reset returns the bus to idle (sclk high, data line released), clears the
// last read byte and loads the timing registers with their defaults.
// timing registers are written through the cfg port, no read-back.
`timescale 1ns / 1ps

module three_wire_sensor_serial_master (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  tws_pkg::tws_in_t    in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output tws_pkg::tws_out_t   out_data_o,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_index_i,
  input  logic [19:0]         cfg_data_i
);

  import tws_pkg::*;

  logic [7:0]       half_q;
  logic [15:0]      sync_low_q;
  logic [19:0]      sync_wait_q;

  phase_e           phase_q, phase_d;
  logic [3:0]       bit_cnt_q, bit_cnt_d;
  logic             high_q, high_d;
  logic [CNT_W-1:0] tick_cnt_q, tick_cnt_d;
  logic [7:0]       shift_q, shift_d;
  logic [7:0]       pend_q, pend_d;
  logic             is_wr_q, is_wr_d;
  logic             lvl_q, lvl_d;
  logic             drv_q, drv_d;
  logic [7:0]       last_rd_q, last_rd_d;

  logic             out_valid_q;
  tws_out_t         out_q, out_d;

  logic             accept;
  logic [CNT_W-1:0] limit, limit_eff, cnt_inc;
  logic [3:0]       bit_inc;
  logic             hit;
  logic             done;
  logic [7:0]       addr_byte;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_q      <= HALF_PERIOD_RST;
      sync_low_q  <= RESYNC_LOW_RST;
      sync_wait_q <= RESYNC_WAIT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_HALF_PERIOD: half_q      <= cfg_data_i[7:0];
        CFG_RESYNC_LOW:  sync_low_q  <= cfg_data_i[15:0];
        CFG_RESYNC_WAIT: sync_wait_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // tick limit for the current phase, zero treated as one
  always_comb begin
    case (phase_q)
      PH_SYNC_LOW:  limit = {4'd0, sync_low_q};
      PH_SYNC_WAIT: limit = sync_wait_q;
      default:      limit = {12'd0, half_q};
    endcase
    limit_eff = (limit == '0) ? CNT_W'(1) : limit;
  end

  assign cnt_inc   = tick_cnt_q + CNT_W'(1);
  assign hit       = cnt_inc >= limit_eff;
  assign bit_inc   = bit_cnt_q + 4'd1;
  assign addr_byte = {(in_data_i.opcode == OP_WRITE), in_data_i.reg_address};

  // next state
  always_comb begin
    phase_d    = phase_q;
    bit_cnt_d  = bit_cnt_q;
    high_d     = high_q;
    tick_cnt_d = tick_cnt_q;
    shift_d    = shift_q;
    pend_d     = pend_q;
    is_wr_d    = is_wr_q;
    lvl_d      = lvl_q;
    drv_d      = drv_q;
    last_rd_d  = last_rd_q;
    done       = 1'b0;

    if (phase_q == PH_IDLE) begin
      case (in_data_i.opcode)
        OP_READ, OP_WRITE: begin
          is_wr_d    = (in_data_i.opcode == OP_WRITE);
          pend_d     = in_data_i.write_data;
          phase_d    = PH_ADDR;
          shift_d    = addr_byte;
          bit_cnt_d  = '0;
          high_d     = 1'b0;
          tick_cnt_d = '0;
          drv_d      = 1'b1;
          lvl_d      = addr_byte[7];
        end
        OP_RESYNC: begin
          phase_d    = PH_SYNC_LOW;
          tick_cnt_d = '0;
          high_d     = 1'b0;
          drv_d      = 1'b0;
          lvl_d      = 1'b0;
        end
        default: ;
      endcase
    end else if (in_data_i.tick) begin
      case (phase_q)
        PH_SYNC_LOW: begin
          tick_cnt_d = hit ? '0 : cnt_inc;
          if (hit) phase_d = PH_SYNC_WAIT;
        end
        PH_SYNC_WAIT: begin
          tick_cnt_d = hit ? '0 : cnt_inc;
          if (hit) begin
            phase_d   = PH_IDLE;
            bit_cnt_d = '0;
            high_d    = 1'b0;
            drv_d     = 1'b0;
            lvl_d     = 1'b0;
            done      = 1'b1;
          end
        end
        PH_ADDR, PH_READ, PH_WRITE: begin
          tick_cnt_d = hit ? '0 : cnt_inc;
          if (hit) begin
            if (!high_q) begin
              // sample just before the rising edge
              if (phase_q == PH_READ) shift_d = {shift_q[6:0], in_data_i.sdio_in};
              high_d = 1'b1;
            end else begin
              bit_cnt_d = bit_inc;
              if (bit_inc >= BITS_PER_BYTE) begin
                bit_cnt_d  = '0;
                high_d     = 1'b0;
                tick_cnt_d = '0;
                if (phase_q == PH_ADDR) begin
                  if (is_wr_q) begin
                    phase_d = PH_WRITE;
                    shift_d = pend_q;
                    drv_d   = 1'b1;
                    lvl_d   = pend_q[7];
                  end else begin
                    phase_d = PH_READ;
                    shift_d = '0;
                    drv_d   = 1'b0;
                    lvl_d   = 1'b0;
                  end
                end else begin
                  if (phase_q == PH_READ) last_rd_d = shift_q;
                  phase_d = PH_IDLE;
                  drv_d   = 1'b0;
                  lvl_d   = 1'b0;
                  done    = 1'b1;
                end
              end else begin
                high_d = 1'b0;
                if (phase_q != PH_READ) begin
                  shift_d = {shift_q[6:0], 1'b0};
                  lvl_d   = shift_q[6];
                end
              end
            end
          end
        end
        default: begin
          phase_d    = PH_IDLE;
          bit_cnt_d  = '0;
          high_d     = 1'b0;
          tick_cnt_d = '0;
          drv_d      = 1'b0;
          lvl_d      = 1'b0;
        end
      endcase
    end
  end

  // output word from the updated state
  always_comb begin
    case (phase_d)
      PH_IDLE, PH_SYNC_WAIT: out_d.sclk = 1'b1;
      PH_SYNC_LOW:           out_d.sclk = 1'b0;
      default:               out_d.sclk = high_d;
    endcase
    out_d.sdio_out   = lvl_d & drv_d;
    out_d.sdio_drive = drv_d;
    out_d.busy_res   = (phase_d != PH_IDLE);
    out_d.done_res   = done;
    out_d.read_data  = last_rd_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_IDLE;
      bit_cnt_q  <= '0;
      high_q     <= 1'b0;
      tick_cnt_q <= '0;
      shift_q    <= '0;
      pend_q     <= '0;
      is_wr_q    <= 1'b0;
      lvl_q      <= 1'b0;
      drv_q      <= 1'b0;
      last_rd_q  <= '0;
    end else if (accept) begin
      phase_q    <= phase_d;
      bit_cnt_q  <= bit_cnt_d;
      high_q     <= high_d;
      tick_cnt_q <= tick_cnt_d;
      shift_q    <= shift_d;
      pend_q     <= pend_d;
      is_wr_q    <= is_wr_d;
      lvl_q      <= lvl_d;
      drv_q      <= drv_d;
      last_rd_q  <= last_rd_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      out_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

/* rtl/tws_checker.sv */
// port-level checker for the three-wire sensor serial master, bound to the top level
`timescale 1ns / 1ps
`include "three_wire_sensor_serial_master_assert.svh"

module tws_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input tws_pkg::tws_out_t out_data_o
);

  import tws_pkg::*;

  // a stalled output word holds
  `TWS_ASSERT_NEXT(out_hold_a, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(out_data_o))

  // every accepted input word gives an output word next cycle
  `TWS_ASSERT_NEXT(in_to_out_a, clk_i, rst_ni, in_valid_i && in_ready_o, out_valid_o)

  // done is never reported together with busy
  `TWS_ASSERT_SAME(done_idle_a, clk_i, rst_ni, out_valid_o && out_data_o.done_res, !out_data_o.busy_res)

  // a released data line shows level zero
  `TWS_ASSERT_SAME(release_low_a, clk_i, rst_ni, out_valid_o && !out_data_o.sdio_drive, !out_data_o.sdio_out)

  // idle bus keeps sclk high and the line released
  `TWS_ASSERT_SAME(idle_pins_a, clk_i, rst_ni, out_valid_o && !out_data_o.busy_res, out_data_o.sclk && !out_data_o.sdio_drive)

endmodule

bind three_wire_sensor_serial_master tws_checker u_tws_checker (.*);
